### sv/mvtr_pkg.sv
// shared types and constants for the mesh vertex transform and rebase block
package mvtr_pkg;

   localparam int DEF_MAX_VERTICES = 65536;
   localparam int DEF_MAX_INDICES  = 262144;

   localparam logic [15:0] W_TOL_RESET = 16'd6;
   localparam logic [15:0] GLOBAL_MAX  = 16'hFFFF;

   typedef enum logic [1:0] {
      ACT_BEGIN  = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_VERTEX = 2'd2,
      ACT_INDEX  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_INDEX  = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_W_OFF    = 3'd1,
      ERR_OVERFLOW = 3'd2,
      ERR_RANGE    = 3'd3,
      ERR_VCAP     = 3'd4,
      ERR_ICAP     = 3'd5
   } error_type;

   // item as taken from the request channel
   typedef struct packed {
      action_type         action;
      logic               has_world;
      logic [16:0]        prim_vertices;
      logic [3:0]         matrix_slot;
      logic [31:0]        matrix_value;
      logic [2:0][31:0]   pos;
      logic [15:0]        local_index;
   } req_item_type;

   // item after the multiplier stage: products of each column, row by row
   typedef struct packed {
      action_type             action;
      logic                   has_world;
      logic [16:0]            prim_vertices;
      logic [2:0][31:0]       pos;
      logic [15:0]            local_index;
      logic [3:0][2:0][63:0]  prod;
      logic [3:0][31:0]       trans;
   } prod_item_type;

   typedef struct packed {
      kind_type     kind;
      logic [31:0]  out_x;
      logic [31:0]  out_y;
      logic [31:0]  out_z;
      logic [15:0]  global_index;
      error_type    error_code;
   } rsp_item_type;

endpackage

### sv/mvtr_xform.sv
// input register, world matrix and the twelve-way product stage
module mvtr_xform (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mvtr_pkg::req_item_type  req_item,
   output logic                    s2_valid,
   input  logic                    s2_ready,
   output mvtr_pkg::prod_item_type s2_item
);

   logic                    s1_valid_ff, s1_valid_in;
   mvtr_pkg::req_item_type  s1_item_ff;
   logic                    s2_valid_ff, s2_valid_in;
   mvtr_pkg::prod_item_type s2_item_ff, s2_item_in;
   logic [15:0][31:0]       matrix_ff;
   logic                    s2_take, s1_move, mat_we;

   assign s2_take   = !s2_valid_ff || s2_ready;
   assign s1_move   = s1_valid_ff && s2_take;
   assign req_ready = !s1_valid_ff || s2_take;
   assign mat_we    = s1_move && (s1_item_ff.action == mvtr_pkg::ACT_LOAD);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         // loads end here, they give no result
         s2_valid_in = (s1_item_ff.action != mvtr_pkg::ACT_LOAD);
      end else if (s2_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   // products taken against the matrix as all earlier loads left it
   always_comb begin
      logic signed [31:0] pa;
      logic signed [31:0] ma;
      logic signed [63:0] pr;
      s2_item_in.action        = s1_item_ff.action;
      s2_item_in.has_world     = s1_item_ff.has_world;
      s2_item_in.prim_vertices = s1_item_ff.prim_vertices;
      s2_item_in.pos           = s1_item_ff.pos;
      s2_item_in.local_index   = s1_item_ff.local_index;
      for (int c = 0; c < 4; c++) begin
         s2_item_in.trans[c] = matrix_ff[4'(12 + c)];
         for (int k = 0; k < 3; k++) begin
            pa = $signed(s1_item_ff.pos[k]);
            ma = $signed(matrix_ff[4'(c + 4 * k)]);
            pr = pa * ma;
            s2_item_in.prod[c][k] = pr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         matrix_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (mat_we) begin
            matrix_ff[s1_item_ff.matrix_slot] <= s1_item_ff.matrix_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_item;
      end
      if (s1_move) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_item  = s2_item_ff;

endmodule

### sv/mvtr_resolve.sv
// column sums, checks, stream counters, error latch and the result register
module mvtr_resolve #(
   parameter int MAX_VERTICES = mvtr_pkg::DEF_MAX_VERTICES,
   parameter int MAX_INDICES  = mvtr_pkg::DEF_MAX_INDICES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data,
   input  logic                    s2_valid,
   output logic                    s2_ready,
   input  mvtr_pkg::prod_item_type s2_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mvtr_pkg::rsp_item_type  rsp_item
);

   localparam int VT_W  = $clog2(MAX_VERTICES + 1);
   localparam int IT_W  = $clog2(MAX_INDICES + 1);
   localparam int PV_W  = 17;
   localparam int CMP_W = (VT_W > PV_W) ? VT_W : PV_W;
   localparam int GI_W  = ((VT_W > 16) ? VT_W : 16) + 1;

   logic [15:0]            w_tol_ff, w_tol_in;
   logic                   use_world_ff, use_world_in;
   logic [VT_W-1:0]        vertex_total_ff, vertex_total_in;
   logic [VT_W-1:0]        primitive_base_ff, primitive_base_in;
   logic [PV_W-1:0]        primitive_count_ff, primitive_count_in;
   logic [IT_W-1:0]        index_total_ff, index_total_in;
   mvtr_pkg::error_type    latched_ff, latched_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mvtr_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                   out_take;
   logic [3:0][49:0]       col;
   logic [3:0]             col_fits;
   logic signed [33:0]     w_dev;
   logic [33:0]            w_mag;
   logic                   w_bad;
   logic [CMP_W-1:0]       room;
   logic [GI_W-1:0]        global_sum;

   assign out_take = !rsp_valid_ff || rsp_ready;
   assign s2_ready = out_take;

   // exact sum of a column in Q32.32, rounded half up to Q16.16
   always_comb begin
      logic signed [65:0] acc;
      for (int c = 0; c < 4; c++) begin
         acc = $signed({{2{s2_item.prod[c][0][63]}}, s2_item.prod[c][0]})
             + $signed({{2{s2_item.prod[c][1][63]}}, s2_item.prod[c][1]})
             + $signed({{2{s2_item.prod[c][2][63]}}, s2_item.prod[c][2]})
             + $signed({{18{s2_item.trans[c][31]}}, s2_item.trans[c], 16'h0000})
             + 66'sd32768;
         col[c]      = acc[65:16];
         col_fits[c] = (col[c][49:31] == '0) || (col[c][49:31] == '1);
      end
   end

   // only looked at once w is known to fit 32 bits
   assign w_dev = $signed({col[3][32], col[3][32:0]}) - 34'sd65536;
   assign w_mag = w_dev[33] ? 34'(-w_dev) : 34'(w_dev);
   assign w_bad = w_mag > {18'b0, w_tol_ff};

   assign room       = CMP_W'(MAX_VERTICES) - CMP_W'(vertex_total_ff);
   assign global_sum = GI_W'(primitive_base_ff) + GI_W'(s2_item.local_index);

   always_comb begin
      logic                   emit;
      mvtr_pkg::rsp_item_type r;
      emit               = 1'b0;
      r                  = '0;
      r.kind             = mvtr_pkg::KIND_ERROR;
      r.error_code       = mvtr_pkg::ERR_NONE;
      w_tol_in           = csr_wr_en ? csr_wr_data : w_tol_ff;
      use_world_in       = use_world_ff;
      vertex_total_in    = vertex_total_ff;
      primitive_base_in  = primitive_base_ff;
      primitive_count_in = primitive_count_ff;
      index_total_in     = index_total_ff;
      latched_in         = latched_ff;

      if (s2_valid && out_take) begin
         if (latched_ff != mvtr_pkg::ERR_NONE) begin
            emit         = 1'b1;
            r.error_code = latched_ff;
         end else begin
            case (s2_item.action)
               mvtr_pkg::ACT_BEGIN: begin
                  if (CMP_W'(s2_item.prim_vertices) > room) begin
                     emit         = 1'b1;
                     r.error_code = mvtr_pkg::ERR_VCAP;
                  end else begin
                     primitive_base_in  = vertex_total_ff;
                     primitive_count_in = s2_item.prim_vertices;
                     use_world_in       = s2_item.has_world;
                  end
               end
               mvtr_pkg::ACT_VERTEX: begin
                  emit = 1'b1;
                  if (vertex_total_ff >= VT_W'(MAX_VERTICES)) begin
                     r.error_code = mvtr_pkg::ERR_VCAP;
                  end else if (use_world_ff && (col_fits != 4'hF)) begin
                     r.error_code = mvtr_pkg::ERR_OVERFLOW;
                  end else if (use_world_ff && w_bad) begin
                     r.error_code = mvtr_pkg::ERR_W_OFF;
                  end else begin
                     r.kind          = mvtr_pkg::KIND_VERTEX;
                     r.out_x         = use_world_ff ? col[0][31:0] : s2_item.pos[0];
                     r.out_y         = use_world_ff ? col[1][31:0] : s2_item.pos[1];
                     r.out_z         = use_world_ff ? col[2][31:0] : s2_item.pos[2];
                     vertex_total_in = vertex_total_ff + VT_W'(1);
                  end
               end
               mvtr_pkg::ACT_INDEX: begin
                  emit = 1'b1;
                  if (index_total_ff >= IT_W'(MAX_INDICES)) begin
                     r.error_code = mvtr_pkg::ERR_ICAP;
                  end else if (PV_W'(s2_item.local_index) >= primitive_count_ff) begin
                     r.error_code = mvtr_pkg::ERR_RANGE;
                  end else if (global_sum > GI_W'(mvtr_pkg::GLOBAL_MAX)) begin
                     r.error_code = mvtr_pkg::ERR_OVERFLOW;
                  end else begin
                     r.kind         = mvtr_pkg::KIND_INDEX;
                     r.global_index = global_sum[15:0];
                     index_total_in = index_total_ff + IT_W'(1);
                  end
               end
               default: begin
               end
            endcase
            if (emit && (r.error_code != mvtr_pkg::ERR_NONE)) begin
               latched_in = r.error_code;
            end
         end
      end

      rsp_item_in  = r;
      rsp_valid_in = out_take ? (s2_valid && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_tol_ff           <= mvtr_pkg::W_TOL_RESET;
         use_world_ff       <= 1'b0;
         vertex_total_ff    <= '0;
         primitive_base_ff  <= '0;
         primitive_count_ff <= '0;
         index_total_ff     <= '0;
         latched_ff         <= mvtr_pkg::ERR_NONE;
         rsp_valid_ff       <= 1'b0;
      end else begin
         w_tol_ff           <= w_tol_in;
         use_world_ff       <= use_world_in;
         vertex_total_ff    <= vertex_total_in;
         primitive_base_ff  <= primitive_base_in;
         primitive_count_ff <= primitive_count_in;
         index_total_ff     <= index_total_in;
         latched_ff         <= latched_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### sv/mesh_vertex_transform_rebase.sv
// mesh merge with affine row-vector vertex transform and index rebase
//
// request channel (req_*): one item per handshake, the action picks a begin,
// a matrix entry load, a vertex or an index. result channel (rsp_*): a vertex,
// a rebased index or an error; loads and good begins give no result.
// csr_wr_en / csr_wr_data write w_tolerance; the user does so only while
// the block is idle, and the block itself does not enforce this.
// an accepted item passes the input register, the product register and
// the result register in turn before its result shows on rsp_*.
// throughput: one item per cycle while results are taken; the product
// stage with twelve 32x32 multipliers and the four column sums behind it
// set the pace. on a stall the result register holds, upstream stages keep
// filling any empty slot and req_ready drops only once all three are full.
// reset (synchronous, active high) zeroes the matrix, counters and error
// latch, sets w_tolerance to 6 and empties the pipeline.
// once an error is latched every begin, vertex and index answers that error
// until reset; matrix loads are still taken.
module mesh_vertex_transform_rebase #(
   parameter int MAX_VERTICES = mvtr_pkg::DEF_MAX_VERTICES,
   parameter int MAX_INDICES  = mvtr_pkg::DEF_MAX_INDICES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic               req_has_world,
   input  logic [16:0]        req_prim_vertices,
   input  logic [3:0]         req_matrix_slot,
   input  logic signed [31:0] req_matrix_value,
   input  logic signed [31:0] req_px,
   input  logic signed [31:0] req_py,
   input  logic signed [31:0] req_pz,
   input  logic [15:0]        req_local_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [15:0]        rsp_global_index,
   output logic [2:0]         rsp_error_code,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   mvtr_pkg::req_item_type  req_item;
   mvtr_pkg::prod_item_type s2_item;
   mvtr_pkg::rsp_item_type  rsp_item;
   logic                    s2_valid, s2_ready;

   always_comb begin
      req_item.action        = mvtr_pkg::action_type'(req_action);
      req_item.has_world     = req_has_world;
      req_item.prim_vertices = req_prim_vertices;
      req_item.matrix_slot   = req_matrix_slot;
      req_item.matrix_value  = req_matrix_value;
      req_item.pos[0]        = req_px;
      req_item.pos[1]        = req_py;
      req_item.pos[2]        = req_pz;
      req_item.local_index   = req_local_index;
   end

   mvtr_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .s2_valid  (s2_valid),
      .s2_ready  (s2_ready),
      .s2_item   (s2_item)
   );

   mvtr_resolve #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_INDICES  (MAX_INDICES)
   ) u_resolve (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .s2_valid    (s2_valid),
      .s2_ready    (s2_ready),
      .s2_item     (s2_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

   assign rsp_result_kind  = rsp_item.kind;
   assign rsp_out_x        = $signed(rsp_item.out_x);
   assign rsp_out_y        = $signed(rsp_item.out_y);
   assign rsp_out_z        = $signed(rsp_item.out_z);
   assign rsp_global_index = rsp_item.global_index;
   assign rsp_error_code   = rsp_item.error_code;

endmodule

### sv/mvtr_checker.sv
// port-level checks for the mesh vertex transform block, bound to the top level
module mvtr_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_result_kind,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z,
   input logic [15:0]        rsp_global_index,
   input logic [2:0]         rsp_error_code
);

   logic rsp_err;
   assign rsp_err = rsp_valid && (rsp_result_kind == mvtr_pkg::KIND_ERROR);

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z)
         && $stable(rsp_global_index) && $stable(rsp_error_code))
      else $error("stalled result changed");

   // an error item carries a code and nothing else
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_err |-> rsp_error_code != mvtr_pkg::ERR_NONE && rsp_out_x == 0
         && rsp_out_y == 0 && rsp_out_z == 0 && rsp_global_index == 0)
      else $error("error item with payload or without code");

   // vertex and index items carry no error code
   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_err |-> rsp_error_code == mvtr_pkg::ERR_NONE)
      else $error("good item with an error code");

   // an index item never carries coordinates
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == mvtr_pkg::KIND_INDEX) |->
         rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0)
      else $error("index item with coordinates");

endmodule

bind mesh_vertex_transform_rebase mvtr_checker u_mvtr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_out_x        (rsp_out_x),
   .rsp_out_y        (rsp_out_y),
   .rsp_out_z        (rsp_out_z),
   .rsp_global_index (rsp_global_index),
   .rsp_error_code   (rsp_error_code)
);

### bench/mesh_vertex_transform_rebase_tb.sv
// testbench for the mesh vertex transform and index rebase block
module mesh_vertex_transform_rebase_tb;
   import mvtr_pkg::*;

   localparam int VERTEX_CAP = DEF_MAX_VERTICES;
   localparam int INDEX_CAP  = DEF_MAX_INDICES;

   typedef logic signed [67:0] wide_type;
   typedef logic [15:0][31:0] matrix_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = '0;
   logic               req_has_world = 1'b0;
   logic [16:0]        req_prim_vertices = '0;
   logic [3:0]         req_matrix_slot = '0;
   logic signed [31:0] req_matrix_value = '0;
   logic signed [31:0] req_px = '0;
   logic signed [31:0] req_py = '0;
   logic signed [31:0] req_pz = '0;
   logic [15:0]        req_local_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic [15:0]        rsp_global_index;
   logic [2:0]         rsp_error_code;
   logic               csr_wr_en = 1'b0;
   logic [15:0]        csr_wr_data = '0;

   mesh_vertex_transform_rebase DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_has_world    (req_has_world),
      .req_prim_vertices(req_prim_vertices),
      .req_matrix_slot  (req_matrix_slot),
      .req_matrix_value (req_matrix_value),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_pz           (req_pz),
      .req_local_index  (req_local_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_global_index (rsp_global_index),
      .rsp_error_code   (rsp_error_code),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // items waiting for the request channel and results the block owes
   req_item_type mesh_items[$];
   rsp_item_type merged_results[$];
   req_item_type req_cur = '0;
   logic         req_taken = 1'b0;
   int           queued_items = 0;
   int           accepted_items = 0;
   int           results_seen = 0;
   int           mismatch_count = 0;
   logic         calm;

   assign calm = (accepted_items >= 400) && (accepted_items < 700);

   // predicted block state
   matrix_type   xf_matrix = '0;
   logic         xf_world = 1'b0;
   int           merged_vertices = 0;
   int           prim_base = 0;
   int           prim_size = 0;
   int           merged_indices = 0;
   error_type    held_error = ERR_NONE;
   logic [15:0]  w_tol = W_TOL_RESET;

   // what the stimulus side has already queued
   matrix_type   plan_matrix = '0;
   logic         plan_world = 1'b0;
   logic [15:0]  plan_tol = W_TOL_RESET;
   int           plan_vertices = 0;
   logic         plan_loose = 1'b0;

   // one output column in Q16.16, products kept exact, rounded half up
   function automatic wide_type column_q16(input matrix_type m, input logic [2:0][31:0] p,
                                           input int col);
      wide_type acc;
      wide_type a;
      wide_type b;
      acc = $signed(m[col + 12]);
      acc = acc <<< 16;
      for (int k = 0; k < 3; k++) begin
         a = $signed(p[k]);
         b = $signed(m[col + 4 * k]);
         acc = acc + a * b;
      end
      return (acc + 32768) >>> 16;
   endfunction

   function automatic error_type transform_check(input matrix_type m,
                                                 input logic [15:0] tol,
                                                 input logic [2:0][31:0] p,
                                                 output logic [2:0][31:0] o);
      wide_type sum [4];
      wide_type dev;
      wide_type limit;
      o = '0;
      for (int c = 0; c < 4; c++) sum[c] = column_q16(m, p, c);
      for (int c = 0; c < 4; c++)
         if (!((sum[c][67:31] == '0) || (&sum[c][67:31]))) return ERR_OVERFLOW;
      dev = sum[3] - 65536;
      if (dev < 0) dev = -dev;
      limit = {52'd0, tol};
      if (dev > limit) return ERR_W_OFF;
      for (int c = 0; c < 3; c++) o[c] = sum[c][31:0];
      return ERR_NONE;
   endfunction

   task automatic latch_error(input error_type code);
      rsp_item_type r;
      r = '0;
      held_error = code;
      r.kind = KIND_ERROR;
      r.error_code = code;
      merged_results.insert(merged_results.size(), r);
   endtask

   task automatic merge_item(input req_item_type it);
      rsp_item_type r;
      error_type e;
      logic [2:0][31:0] o;
      r = '0;
      if (it.action == ACT_LOAD) begin
         xf_matrix[it.matrix_slot] = it.matrix_value;
         return;
      end
      if (held_error != ERR_NONE) begin
         latch_error(held_error);
         return;
      end
      case (it.action)
         ACT_BEGIN: begin
            if (merged_vertices > VERTEX_CAP || it.prim_vertices > VERTEX_CAP - merged_vertices)
               latch_error(ERR_VCAP);
            else begin
               prim_base = merged_vertices;
               prim_size = it.prim_vertices;
               xf_world = it.has_world;
            end
         end
         ACT_VERTEX: begin
            if (merged_vertices >= VERTEX_CAP) begin
               latch_error(ERR_VCAP);
               return;
            end
            if (xf_world) begin
               e = transform_check(xf_matrix, w_tol, it.pos, o);
               if (e != ERR_NONE) begin
                  latch_error(e);
                  return;
               end
            end else
               o = it.pos;
            merged_vertices++;
            r.kind = KIND_VERTEX;
            r.out_x = o[0];
            r.out_y = o[1];
            r.out_z = o[2];
            r.error_code = ERR_NONE;
            merged_results.insert(merged_results.size(), r);
         end
         default: begin
            if (merged_indices >= INDEX_CAP) latch_error(ERR_ICAP);
            else if (it.local_index >= prim_size) latch_error(ERR_RANGE);
            else if (prim_base + it.local_index > 65535) latch_error(ERR_OVERFLOW);
            else begin
               merged_indices++;
               r.kind = KIND_INDEX;
               r.global_index = 16'(prim_base + it.local_index);
               r.error_code = ERR_NONE;
               merged_results.insert(merged_results.size(), r);
            end
         end
      endcase
   endtask

   task automatic flag_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
   endtask

   // request driver
   always @(negedge clock) begin : drive
      req_item_type next_item;
      if (reset)
         req_valid <= 1'b0;
      else if (!req_valid || req_taken) begin
         if (mesh_items.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
            next_item = mesh_items.pop_front();
            req_cur <= next_item;
            req_valid <= 1'b1;
            req_action <= next_item.action;
            req_has_world <= next_item.has_world;
            req_prim_vertices <= next_item.prim_vertices;
            req_matrix_slot <= next_item.matrix_slot;
            req_matrix_value <= next_item.matrix_value;
            req_px <= next_item.pos[0];
            req_py <= next_item.pos[1];
            req_pz <= next_item.pos[2];
            req_local_index <= next_item.local_index;
         end else
            req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 34);
   end

   // predictor and result checker
   always @(posedge clock) begin : observe
      rsp_item_type want;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (csr_wr_en) w_tol = csr_wr_data;
         if (req_valid && req_ready) begin
            merge_item(req_cur);
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (merged_results.size() == 0)
               flag_mismatch($sformatf("result %0d arrived with none pending", results_seen));
            else begin
               want = merged_results.pop_front();
               check_field("kind", rsp_result_kind, want.kind);
               check_field("out_x", rsp_out_x, want.out_x);
               check_field("out_y", rsp_out_y, want.out_y);
               check_field("out_z", rsp_out_z, want.out_z);
               check_field("global_index", rsp_global_index, want.global_index);
               check_field("error_code", rsp_error_code, want.error_code);
            end
            results_seen++;
         end
      end
   end

   function automatic req_item_type random_item();
      req_item_type it;
      it.action = action_type'($urandom_range(3));
      it.has_world = $urandom_range(1);
      it.prim_vertices = $urandom;
      it.matrix_slot = $urandom;
      it.matrix_value = $urandom;
      it.pos = {$urandom, $urandom, $urandom};
      it.local_index = $urandom;
      return it;
   endfunction

   // matrix entry that keeps bounded vertices in range and w within tolerance
   function automatic logic [31:0] sane_entry(input int slot);
      int pick;
      pick = $urandom_range(3);
      case (slot)
         12, 13, 14: return $signed($urandom) >>> 3;
         3, 7, 11: return (pick == 0) ? $urandom_range(6) - 3 : 0;
         15: return 65536 - int'(plan_tol) + $urandom_range(2 * int'(plan_tol));
         default: begin
            if (pick == 0) return 0;
            if (pick == 1) return $urandom_range(1) ? 32'sd65536 : -32'sd65536;
            return $signed($urandom) >>> 14;
         end
      endcase
   endfunction

   task automatic queue_item(input req_item_type it);
      mesh_items.insert(mesh_items.size(), it);
      queued_items++;
   endtask

   task automatic send_load(input logic [3:0] slot, input logic [31:0] value);
      req_item_type it;
      it = random_item();
      it.action = ACT_LOAD;
      it.matrix_slot = slot;
      it.matrix_value = value;
      plan_matrix[slot] = value;
      queue_item(it);
   endtask

   task automatic send_begin(input logic world, input int count);
      req_item_type it;
      it = random_item();
      it.action = ACT_BEGIN;
      it.has_world = world;
      it.prim_vertices = count;
      plan_world = world;
      queue_item(it);
   endtask

   // vertices under a matrix are shrunk until they transform without fault
   task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
      req_item_type it;
      logic [2:0][31:0] o;
      it = random_item();
      it.action = ACT_VERTEX;
      it.pos = {z, y, x};
      if (plan_world) begin
         if (transform_check(plan_matrix, plan_tol, it.pos, o) != ERR_NONE)
            it.pos = {$signed(z) >>> 12, $signed(y) >>> 12, $signed(x) >>> 12};
         if (transform_check(plan_matrix, plan_tol, it.pos, o) != ERR_NONE)
            it.pos = '0;
      end
      plan_vertices++;
      queue_item(it);
   endtask

   task automatic send_index(input logic [15:0] local_idx);
      req_item_type it;
      it = random_item();
      it.action = ACT_INDEX;
      it.local_index = local_idx;
      queue_item(it);
   endtask

   task automatic settle();
      while (accepted_items != queued_items || merged_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_tolerance(input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      plan_tol = value;
      plan_loose = 1'b1;
   endtask

   initial begin : stimulus
      req_item_type it;
      logic world;
      int room;
      int count;
      int nv;
      int ni;
      int pick;
      int s;
      int target;
      int scenario;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // whole vertex capacity in one primitive, then extreme indices and passthrough
      send_begin(1'b0, VERTEX_CAP);
      send_index(16'hFFFF);
      send_index(16'h0000);
      send_vertex(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
      send_vertex(32'h0, 32'h0, 32'h0);
      // identity with w at the upper tolerance edge
      send_load(0, 32'd65536);
      send_load(5, 32'd65536);
      send_load(10, 32'd65536);
      send_load(15, 32'd65542);
      send_begin(1'b1, 4);
      send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
      // half scale: rounding ties go toward plus infinity
      send_load(0, 32'd32768);
      send_vertex(32'd1, 32'd0, 32'd0);
      send_vertex(32'hFFFFFFFF, 32'd0, 32'd0);
      send_index(16'd3);
      send_load(15, 32'd65530);
      send_vertex(32'd65536, 32'd65536, 32'd65536);
      // empty primitive still takes vertices past its count
      send_begin(1'b1, 0);
      send_vertex(32'h00018000, 32'hFFFE8000, 32'd7);
      plan_loose = 1'b1;

      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1: write_tolerance(16'd0);
               2: write_tolerance(16'hFFFF);
               3: write_tolerance($urandom_range(7, 40));
               default: write_tolerance(16'd1);
            endcase
         end
         target = queued_items + 300;
         while (queued_items < target) begin
            world = ($urandom_range(99) < 60);
            if (world) begin
               if (plan_loose) begin
                  for (s = 0; s < 16; s++) send_load(s, sane_entry(s));
                  plan_loose = 1'b0;
               end else
                  repeat ($urandom_range(3)) begin
                     s = $urandom_range(15);
                     send_load(s, sane_entry(s));
                  end
            end else if ($urandom_range(3) == 0) begin
               repeat ($urandom_range(1, 6)) send_load($urandom_range(15), $urandom);
               plan_loose = 1'b1;
            end
            room = VERTEX_CAP - plan_vertices;
            pick = $urandom_range(99);
            if (pick < 5) count = 0;
            else if (pick < 9) count = room;
            else count = $urandom_range(1, 24);
            if (count > room) count = room;
            send_begin(world, count);
            nv = (count > 24) ? $urandom_range(1, 24) : count;
            if ($urandom_range(9) == 0) nv += $urandom_range(1, 3);
            else if (nv > 0 && $urandom_range(9) == 0) nv--;
            ni = (count == 0) ? 0 : $urandom_range(30);
            while (nv + ni > 0) begin
               if ($urandom_range(29) == 0) begin
                  s = $urandom_range(15);
                  if (world) send_load(s, sane_entry(s));
                  else begin
                     send_load(s, $urandom);
                     plan_loose = 1'b1;
                  end
               end
               if ($urandom_range(nv + ni - 1) < nv) begin
                  if (world) begin
                     pick = $urandom_range(2);
                     s = (pick == 0) ? 4 : (pick == 1) ? 9 : 15;
                     send_vertex($signed($urandom) >>> s, $signed($urandom) >>> s,
                                 $signed($urandom) >>> s);
                  end else
                     send_vertex($urandom, $urandom, $urandom);
                  nv--;
               end else begin
                  pick = $urandom_range(7);
                  send_index((pick == 0) ? count - 1 :
                             (pick == 1) ? 0 : $urandom_range(count - 1));
                  ni--;
               end
            end
         end
      end

      // one fault latches for good, everything after answers it
      settle();
      scenario = $urandom_range(3);
      case (scenario)
         0: begin
            send_load(3, 32'd0);
            send_load(7, 32'd0);
            send_load(11, 32'd0);
            send_load(15, $urandom_range(1) ? 32'd65537 + plan_tol : 32'd65535 - plan_tol);
            send_begin(1'b1, 1);
            it = random_item();
            it.action = ACT_VERTEX;
            it.pos = '0;
            queue_item(it);
         end
         1: begin
            send_load(0, 32'h7FFFFFFF);
            send_begin(1'b1, 1);
            it = random_item();
            it.action = ACT_VERTEX;
            it.pos = {32'd0, 32'd0, 32'h7FFFFFFF};
            queue_item(it);
         end
         2: begin
            count = $urandom_range(20);
            send_begin(1'b0, count);
            it = random_item();
            it.action = ACT_INDEX;
            it.local_index = count + $urandom_range(100);
            queue_item(it);
         end
         default: begin
            it = random_item();
            it.action = ACT_BEGIN;
            it.prim_vertices = $urandom_range(131071, VERTEX_CAP - plan_vertices + 1);
            queue_item(it);
         end
      endcase
      repeat (40) queue_item(random_item());
      settle();

      if (mismatch_count == 0)
         $display("mesh_vertex_transform_rebase_tb: PASS");
      else
         $display("mesh_vertex_transform_rebase_tb: FAIL");
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("mesh_vertex_transform_rebase_tb: FAIL");
      $finish;
   end

endmodule
